>>> rtl/tdpf_pkg.sv
// ----------------------------------------------------------------------------
// tdpf_pkg
// Shared types and constants for the timed duplicate packet filter.
// ----------------------------------------------------------------------------
package tdpf_pkg;

  localparam int unsigned KeyW  = 64;
  localparam int unsigned TimeW = 32;
  localparam int unsigned LifeW = 8;

  // lifetime register value after reset, in seconds
  localparam logic [LifeW-1:0] LifetimeReset = 8'd60;

  // request mode codes
  localparam logic ModeCheck = 1'b0;
  localparam logic ModeClear = 1'b1;

  // classified request handed from the front to the back
  typedef struct packed {
    logic             clear;
    logic [KeyW-1:0]  key;
    logic [TimeW-1:0] now;
  } req_t;

  // one table slot as stored in memory
  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [TimeW-1:0] second;
  } slot_t;

  localparam int unsigned SlotW = $bits(slot_t);

  typedef enum logic [1:0] {
    BackIdle,
    BackScan,
    BackFin
  } back_state_e;

endpackage

>>> rtl/tdpf_ram.sv
// ----------------------------------------------------------------------------
// tdpf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tdpf_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tdpf_front.sv
// ----------------------------------------------------------------------------
// tdpf_front
// Accepts requests, classifies them into check or clear, and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module tdpf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                mode_i,
  input  logic [31:0]         cmd_i,
  input  logic [31:0]         seq_i,
  input  logic [31:0]         now_seconds_i,
  output logic                req_valid_o,
  output tdpf_pkg::req_t      req_o,
  input  logic                req_pop_i
);

  tdpf_pkg::req_t fifo_q [2];
  tdpf_pkg::req_t req_in;
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q, cnt_d;
  logic           push_ok, pop_ok;

  // classify the incoming request
  always_comb begin
    req_in.clear = (mode_i == tdpf_pkg::ModeClear);
    req_in.key   = {cmd_i, seq_i};
    req_in.now   = now_seconds_i;
  end

  assign full        = (cnt_q == 2'd2);
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = fifo_q[rptr_q];
  assign push_ok     = push && !full;
  assign pop_ok      = req_pop_i && req_valid_o;

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_ok) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_ok) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      fifo_q[wptr_q] <= req_in;
    end
  end

endmodule

>>> rtl/tdpf_back.sv
// ----------------------------------------------------------------------------
// tdpf_back
// Scans the slot table one entry per cycle, decides duplicate / record /
// overflow, updates the table and holds the result for the consumer.
// Slots [0, fill) are the valid ones; a clear resets the fill count.
// ----------------------------------------------------------------------------
module tdpf_back #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          lifetime_i,
  input  logic                req_valid_i,
  input  tdpf_pkg::req_t      req_i,
  output logic                req_pop_o,
  output logic                empty,
  input  logic                pop,
  output logic                duplicate_o,
  output logic                overflow_o
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  tdpf_pkg::back_state_e state_q, state_d;
  tdpf_pkg::req_t        cur_q;
  tdpf_pkg::slot_t       rd_slot, wr_slot;

  logic [CW-1:0] fill_q, fill_m1;
  logic [AW-1:0] rd_ptr_q, cmp_idx_q, free_idx_q, ram_waddr, last_idx;
  logic          issue_q, cmp_valid_q, cmp_last_q;
  logic          dup_hit_q, free_hit_q;
  logic          out_valid_q, out_dup_q, out_ovf_q;

  logic                          out_free, start_scan, ram_re, ram_we, fin_fire;
  logic                          res_dup, res_ovf, fill_clr, fill_inc;
  logic [tdpf_pkg::TimeW-1:0]    age;
  logic                          live, key_eq;

  assign out_free = !out_valid_q || pop;
  assign fill_m1  = fill_q - CW'(1);
  assign last_idx = fill_m1[AW-1:0];

  // age check of the slot read this cycle
  always_comb begin
    age    = cur_q.now - rd_slot.second;
    live   = (age[tdpf_pkg::TimeW-1:tdpf_pkg::LifeW] == '0) &&
             (age[tdpf_pkg::LifeW-1:0] < lifetime_i);
    key_eq = (rd_slot.key == cur_q.key);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tdpf_pkg::BackIdle: begin
        if (req_valid_i) begin
          if (req_i.clear || (fill_q == '0)) begin
            state_d = tdpf_pkg::BackFin;
          end else begin
            state_d = tdpf_pkg::BackScan;
          end
        end
      end
      tdpf_pkg::BackScan: begin
        if (cmp_valid_q && cmp_last_q) begin
          state_d = tdpf_pkg::BackFin;
        end
      end
      tdpf_pkg::BackFin: begin
        if (out_free) begin
          state_d = tdpf_pkg::BackIdle;
        end
      end
      default: state_d = tdpf_pkg::BackIdle;
    endcase
  end

  // outputs and decision
  always_comb begin
    req_pop_o  = (state_q == tdpf_pkg::BackIdle) && req_valid_i;
    start_scan = req_pop_o && !req_i.clear && (fill_q != '0);
    ram_re     = (state_q == tdpf_pkg::BackScan) && issue_q;
    fin_fire   = (state_q == tdpf_pkg::BackFin) && out_free;
    res_dup    = 1'b0;
    res_ovf    = 1'b0;
    fill_clr   = 1'b0;
    fill_inc   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = free_idx_q;
    if (cur_q.clear) begin
      fill_clr = fin_fire;
    end else if (dup_hit_q) begin
      res_dup = 1'b1;
    end else if (free_hit_q) begin
      ram_we = fin_fire;
    end else if (fill_q != CW'(TABLE_ENTRIES)) begin
      ram_we    = fin_fire;
      ram_waddr = fill_q[AW-1:0];
      fill_inc  = fin_fire;
    end else begin
      res_ovf = 1'b1;
    end
    wr_slot.key    = cur_q.key;
    wr_slot.second = cur_q.now;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdpf_pkg::BackIdle;
      fill_q      <= '0;
      issue_q     <= 1'b0;
      cmp_valid_q <= 1'b0;
      dup_hit_q   <= 1'b0;
      free_hit_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmp_valid_q <= ram_re;
      // scan issue
      if (start_scan) begin
        issue_q <= 1'b1;
      end else if (ram_re && (rd_ptr_q == last_idx)) begin
        issue_q <= 1'b0;
      end
      // compare stage
      if (req_pop_o) begin
        dup_hit_q  <= 1'b0;
        free_hit_q <= 1'b0;
      end else if (cmp_valid_q) begin
        if (live && key_eq) begin
          dup_hit_q <= 1'b1;
        end
        if (!live) begin
          free_hit_q <= 1'b1;
        end
      end
      // fill count
      if (fill_clr) begin
        fill_q <= '0;
      end else if (fill_inc) begin
        fill_q <= fill_q + CW'(1);
      end
      // result register
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_pop_o) begin
      cur_q <= req_i;
    end
    if (start_scan) begin
      rd_ptr_q <= '0;
    end else if (ram_re) begin
      rd_ptr_q <= rd_ptr_q + AW'(1);
    end
    if (ram_re) begin
      cmp_idx_q  <= rd_ptr_q;
      cmp_last_q <= (rd_ptr_q == last_idx);
    end
    // lowest non-live slot wins
    if (cmp_valid_q && !live && !free_hit_q) begin
      free_idx_q <= cmp_idx_q;
    end
    if (fin_fire) begin
      out_dup_q <= res_dup;
      out_ovf_q <= res_ovf;
    end
  end

  tdpf_ram #(
    .WIDTH (tdpf_pkg::SlotW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_slot),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (rd_slot)
  );

  assign empty       = !out_valid_q;
  assign duplicate_o = out_dup_q;
  assign overflow_o  = out_ovf_q;

  // checks
  a_dup_ovf_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_dup_q && out_ovf_q))
    else $error("duplicate and overflow both set");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_cmp_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_valid_q |-> (state_q == tdpf_pkg::BackScan))
    else $error("compare stage active outside scan");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CW'(ram_waddr) <= fill_q))
    else $error("slot write beyond fill count");

endmodule

>>> rtl/timed_duplicate_packet_filter.sv
// ----------------------------------------------------------------------------
// timed_duplicate_packet_filter
// Flags packets whose (cmd, seq) key was seen within the lifetime window and
// records new keys in a slot table; a clear request empties the table.
// ----------------------------------------------------------------------------
// Flow: an accepted request waits in the request queue until the back end is
//   idle; a clear or a request on an empty table goes straight to the result,
//   otherwise the table memory is scanned one slot per cycle over the fill slots recorded since the last clear.
// Flow control: the back end serves one request at a time, while the queue
//   can take new requests during a scan; a 2-entry request queue and a result
//   register let both sides stall independently.
// Reset: table empty (fill count zero, no clearing pass), lifetime 60 s.
// ----------------------------------------------------------------------------
module timed_duplicate_packet_filter #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        lifetime_we_i,
  input  logic [7:0]  lifetime_seconds_i,
  input  logic        push,
  output logic        full,
  input  logic        mode_i,
  input  logic [31:0] cmd_i,
  input  logic [31:0] seq_i,
  input  logic [31:0] now_seconds_i,
  output logic        empty,
  input  logic        pop,
  output logic        duplicate_o,
  output logic        overflow_o
);

  logic           lifetime_q;
  logic [7:0]     lifetime_val_q;
  logic           req_valid, req_pop;
  tdpf_pkg::req_t req;

  // lifetime register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lifetime_val_q <= tdpf_pkg::LifetimeReset;
      lifetime_q     <= 1'b0;
    end else begin
      lifetime_q <= lifetime_we_i;
      if (lifetime_we_i) begin
        lifetime_val_q <= lifetime_seconds_i;
      end
    end
  end

  tdpf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .mode_i        (mode_i),
    .cmd_i         (cmd_i),
    .seq_i         (seq_i),
    .now_seconds_i (now_seconds_i),
    .req_valid_o   (req_valid),
    .req_o         (req),
    .req_pop_i     (req_pop)
  );

  tdpf_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lifetime_i  (lifetime_val_q),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_pop_o   (req_pop),
    .empty       (empty),
    .pop         (pop),
    .duplicate_o (duplicate_o),
    .overflow_o  (overflow_o)
  );

  // a config write is never expected while a request is in flight
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lifetime_q |-> !req_pop)
    else $error("lifetime written while a request was being started");

endmodule
